// ----- rtl/pose_dead_reckoning_update_core_defines.svh -----
// Assertion macros used by the checker file of the pose update core.
// Depends on nothing; included by the checker module.
`ifndef POSE_DEAD_RECKONING_UPDATE_CORE_DEFINES_SVH
`define POSE_DEAD_RECKONING_UPDATE_CORE_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define PDR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdr check failed");
// Next-cycle implication checked outside reset.
`define PDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdr check failed");
`endif

// ----- rtl/pdr_pkg.sv -----
// Package for the pose update core: state encoding, commands, CORDIC constants.
// Depends on nothing.
package pdr_pkg;
  localparam int AngW = 17;
  localparam int CordW = 34;
  localparam int ZW = 26;
  localparam int FullTurn = 46080;
  localparam int HalfTurn = 23040;
  localparam int QuarterTurn = 11520;
  localparam logic signed [CordW-1:0] CordicStart = 34'sd652032874;

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_ROT_WRAP, S_CS1_START, S_CS1_RUN, S_CS2_START, S_CS2_RUN,
    S_MUL1, S_MUL2, S_MUL3, S_ADD, S_CS3_START, S_CS3_RUN, S_OUT
  } pdr_state_t;

  typedef struct packed {
    logic load;         // capture input beat
    logic rot_add;      // heading += angle
    logic rot_wrap;     // wrap heading one turn
    logic cs_start;     // start CORDIC
    logic cs_sel_ang;   // CORDIC argument: 1 climb angle, 0 heading
    logic cs_step;      // one CORDIC iteration
    logic save_head;    // keep heading sin/cos
    logic save_climb;   // keep climb sin/cos
    logic mul1;
    logic mul2;
    logic mul3;
    logic pos_add;
    logic out_load;
  } pdr_cmd_t;

  typedef struct packed {
    logic is_rotate;
    logic wrap_done;
    logic cs_done;
  } pdr_sts_t;

  function automatic logic signed [ZW-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        5'd0: r = 26'sd2949120;  5'd1: r = 26'sd1740967; 5'd2: r = 26'sd919879;
        5'd3: r = 26'sd466945;   5'd4: r = 26'sd234379;  5'd5: r = 26'sd117304;
        5'd6: r = 26'sd58666;    5'd7: r = 26'sd29335;   5'd8: r = 26'sd14668;
        5'd9: r = 26'sd7334;     5'd10: r = 26'sd3667;   5'd11: r = 26'sd1833;
        5'd12: r = 26'sd917;     5'd13: r = 26'sd458;    5'd14: r = 26'sd229;
        5'd15: r = 26'sd115;     5'd16: r = 26'sd57;     5'd17: r = 26'sd29;
        5'd18: r = 26'sd14;      5'd19: r = 26'sd7;      5'd20: r = 26'sd4;
        5'd21: r = 26'sd2;       5'd22: r = 26'sd1;      default: r = '0;
      endcase
      return r;
    end
  endfunction
endpackage

// ----- rtl/pdr_ctrl.sv -----
// Controller state machine of the pose update core.
// Depends on pdr_pkg.
module pdr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  pdr_pkg::pdr_sts_t sts,
  output pdr_pkg::pdr_cmd_t cmd
);
  import pdr_pkg::*;
  pdr_state_t state, state_next;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  // The output register frees the core as soon as a result is loaded.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_HEAD;
      S_HEAD: state_next = sts.is_rotate ? S_ROT_WRAP : S_CS1_START;
      S_ROT_WRAP: if (sts.wrap_done) state_next = S_CS3_START;
      S_CS1_START: state_next = S_CS1_RUN;
      S_CS1_RUN: if (sts.cs_done) state_next = S_CS2_START;
      S_CS2_START: state_next = S_CS2_RUN;
      S_CS2_RUN: if (sts.cs_done) state_next = S_MUL1;
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_MUL3;
      S_MUL3: state_next = S_ADD;
      S_ADD: state_next = S_CS3_START;
      S_CS3_START: state_next = S_CS3_RUN;
      S_CS3_RUN: if (sts.cs_done) state_next = S_OUT;
      S_OUT: if (!out_full || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_full_next = out_full && out_stall;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_HEAD: cmd.rot_add = sts.is_rotate;
      S_ROT_WRAP: cmd.rot_wrap = !sts.wrap_done;
      S_CS1_START: cmd.cs_start = 1'b1;
      S_CS1_RUN: begin
        cmd.cs_step = !sts.cs_done;
        cmd.save_head = sts.cs_done;
      end
      S_CS2_START: begin
        cmd.cs_start = 1'b1;
        cmd.cs_sel_ang = 1'b1;
      end
      S_CS2_RUN: begin
        cmd.cs_step = !sts.cs_done;
        cmd.save_climb = sts.cs_done;
      end
      S_MUL1: cmd.mul1 = 1'b1;
      S_MUL2: cmd.mul2 = 1'b1;
      S_MUL3: cmd.mul3 = 1'b1;
      S_ADD: cmd.pos_add = 1'b1;
      S_CS3_START: cmd.cs_start = 1'b1;
      S_CS3_RUN: begin
        cmd.cs_step = !sts.cs_done;
        cmd.save_head = sts.cs_done;
      end
      S_OUT: begin
        if (!out_full || !out_stall) begin
          cmd.out_load = 1'b1;
          out_full_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_full;
endmodule

// ----- rtl/pdr_dpath.sv -----
// Datapath of the pose update core: heading, iterative CORDIC, multiplies, position.
// Depends on pdr_pkg.
module pdr_dpath #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  pdr_pkg::pdr_cmd_t cmd,
  output pdr_pkg::pdr_sts_t sts,
  input  logic operation,
  input  logic signed [16:0] angle,
  input  logic signed [23:0] distance,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [16:0] heading,
  output logic signed [15:0] cos_heading,
  output logic signed [15:0] sin_heading
);
  import pdr_pkg::*;
  localparam int Steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam logic [4:0] LastStep = 5'(Steps - 1);
  localparam logic signed [POS_WIDTH-1:0] PMax = {1'b0, {(POS_WIDTH-1){1'b1}}};
  localparam logic signed [POS_WIDTH-1:0] PMin = {1'b1, {(POS_WIDTH-1){1'b0}}};

  logic op_r;
  logic signed [16:0] ang_r;
  logic signed [23:0] dist_r;
  logic signed [18:0] head;
  logic signed [POS_WIDTH-1:0] px, py, pz;
  logic signed [CordW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic [4:0] cstep;
  logic cbusy, cneg;
  logic signed [15:0] ch, sh, cr, sr;
  logic signed [31:0] p_cc, p_sc;
  logic signed [55:0] dx, dy;
  logic signed [40:0] dz;

  assign sts.is_rotate = op_r;
  assign sts.wrap_done = (head < 19'sd46080) && (head > -19'sd46080);
  assign sts.cs_done = !cbusy;

  // Reduce the argument to [-90, 90] degrees; the cosine sign is kept aside.
  logic signed [18:0] a_in, a_red, a_fold;
  logic fold;
  always_comb begin
    a_in = cmd.cs_sel_ang ? 19'(ang_r) : head;
    a_red = a_in;
    if (a_in > 19'sd23040) a_red = a_in - 19'sd46080;
    if (a_red > 19'sd23040) a_red = a_red - 19'sd46080;
    if (a_red <= -19'sd23040) a_red = a_red + 19'sd46080;
    if (a_red <= -19'sd23040) a_red = a_red + 19'sd46080;
    fold = 1'b0;
    a_fold = a_red;
    if (a_red > 19'sd11520) begin
      a_fold = 19'sd23040 - a_red;
      fold = 1'b1;
    end else if (a_red < -19'sd11520) begin
      a_fold = -19'sd23040 - a_red;
      fold = 1'b1;
    end
  end

  logic signed [CordW-1:0] xs, ys;
  assign xs = cx >>> cstep;
  assign ys = cy >>> cstep;

  // Round to Q1.15, saturate, and negate the cosine when folded.
  function automatic logic signed [15:0] rnd(input logic signed [CordW-1:0] v,
                                             input logic neg);
    logic signed [CordW-1:0] t;
    logic signed [CordW-1:0] q;
    begin
      t = (v + CordW'(32'sd16384)) >>> 15;
      q = t;
      if (t > CordW'(32'sd32767)) q = CordW'(32'sd32767);
      if (t < -CordW'(32'sd32768)) q = -CordW'(32'sd32768);
      if (neg) begin
        q = -q;
        if (q > CordW'(32'sd32767)) q = CordW'(32'sd32767);
      end
      return q[15:0];
    end
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] sat_add(
      input logic signed [POS_WIDTH-1:0] p, input logic signed [55:0] d);
    logic signed [POS_WIDTH+56:0] s;
    begin
      s = (POS_WIDTH+57)'(p) + (POS_WIDTH+57)'(d);
      if (s > (POS_WIDTH+57)'(PMax)) return PMax;
      if (s < (POS_WIDTH+57)'(PMin)) return PMin;
      return s[POS_WIDTH-1:0];
    end
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [POS_WIDTH-1:0] p);
    logic signed [POS_WIDTH+32:0] w;
    begin
      w = (POS_WIDTH+33)'(p);
      if (w > (POS_WIDTH+33)'(64'sd2147483647)) return 32'sh7fffffff;
      if (w < -(POS_WIDTH+33)'(64'sd2147483648)) return 32'sh80000000;
      return w[31:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      px <= '0;
      py <= '0;
      pz <= '0;
      cbusy <= 1'b0;
    end else begin
      if (cmd.rot_add) head <= head + 19'(ang_r);
      if (cmd.rot_wrap) head <= (head > 19'sd0) ? head - 19'sd46080 : head + 19'sd46080;
      if (cmd.cs_start) cbusy <= 1'b1;
      else if (cmd.cs_step && cstep == LastStep) cbusy <= 1'b0;
      if (cmd.pos_add) begin
        px <= sat_add(px, dx);
        py <= sat_add(py, dy);
        pz <= sat_add(pz, 56'(dz));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= operation;
      ang_r <= angle;
      dist_r <= distance;
    end
    if (cmd.cs_start) begin
      cx <= CordicStart;
      cy <= '0;
      cz <= ZW'(a_fold) <<< 9;
      cneg <= fold;
      cstep <= '0;
    end else if (cmd.cs_step) begin
      if (!cz[ZW-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_val(cstep);
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_val(cstep);
      end
      cstep <= cstep + 5'd1;
    end
    if (cmd.save_head) begin
      ch <= rnd(cx, cneg);
      sh <= rnd(cy, 1'b0);
    end
    if (cmd.save_climb) begin
      cr <= rnd(cx, cneg);
      sr <= rnd(cy, 1'b0);
    end
    if (cmd.mul1) begin
      p_cc <= ch * cr;
      p_sc <= sh * cr;
    end
    // The full product of a Q2.30 factor and a 24-bit distance needs 56 bits.
    if (cmd.mul2) begin
      dx <= 56'sd0 + p_cc * dist_r;
      dy <= 56'sd0 + p_sc * dist_r;
    end
    if (cmd.mul3) begin
      dx <= (dx + 56'sd536870912) >>> 30;
      dy <= (dy + 56'sd536870912) >>> 30;
      dz <= (41'(sr) * 41'(dist_r) + 41'sd16384) >>> 15;
    end
    if (cmd.out_load) begin
      pos_x <= clip32(px);
      pos_y <= clip32(py);
      pos_z <= clip32(pz);
      heading <= head[16:0];
      cos_heading <= ch;
      sin_heading <= sh;
    end
  end
endmodule

// ----- rtl/pose_dead_reckoning_update_core.sv -----
// Pose dead-reckoning update core: one beat in, one beat out.
// A rotate adds the angle to the heading and wraps it by one turn, at most twice;
// a move runs the shared CORDIC on heading and climb angle, multiplies, and adds
// to the position. Both end with a CORDIC run for the heading sine and cosine. One
// item at a time: the next beat is taken the cycle after the result is loaded into
// the output register. Synchronous reset clears position and heading to zero.
module pose_dead_reckoning_update_core #(
  parameter int CORDIC_STEPS = 16,
  parameter int POS_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic operation,
  input  logic signed [16:0] angle,
  input  logic signed [23:0] distance,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [16:0] heading,
  output logic signed [15:0] cos_heading,
  output logic signed [15:0] sin_heading
);
  import pdr_pkg::*;
  pdr_cmd_t cmd;
  pdr_sts_t sts;

  pdr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  pdr_dpath #(.CORDIC_STEPS(CORDIC_STEPS), .POS_WIDTH(POS_WIDTH)) u_dpath (
    .clk, .rst, .cmd, .sts, .operation, .angle, .distance,
    .pos_x, .pos_y, .pos_z, .heading, .cos_heading, .sin_heading
  );
endmodule

// ----- rtl/pdr_checker.sv -----
// Port checker for the pose update core, bound to the top level.
// Depends on the defines header.
`include "pose_dead_reckoning_update_core_defines.svh"
module pdr_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic signed [16:0] heading
);
  `PDR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `PDR_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && !in_stall, in_stall)
  `PDR_ASSERT_IMPL(a_head_range, clk, rst, out_valid,
    heading < 17'sd46080 && heading > -17'sd46080)
  `PDR_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(heading))
endmodule

bind pose_dead_reckoning_update_core pdr_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .heading
);
